[hw/rtl/round_robin_cpu_scheduler_macros.svh]
//------------------------------------------------------------------------------
// Round-robin scheduler assertion macros
// Shared property forms for the scheduler's concurrent checks.
//------------------------------------------------------------------------------
`ifndef ROUND_ROBIN_CPU_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_CPU_SCHEDULER_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define RRS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define RRS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/rrs_pkg.sv]
//------------------------------------------------------------------------------
// Round-robin scheduler package
// Beat types, command codes and shared constants.
//------------------------------------------------------------------------------
package rrs_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int TIME_W = 22;
  localparam int PID_W = 4;
  localparam logic [15:0] QUANTUM_RESET = 16'd4;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] arrival_tick;
    logic [15:0] burst_ticks;
  } in_t;

  typedef struct packed {
    logic              status;
    logic [PID_W-1:0]  process_id;
    logic [15:0]       slice_length;
    logic [TIME_W-1:0] slice_end_time;
    logic              finished;
    logic [TIME_W-1:0] wait_ticks;
    logic [TIME_W-1:0] turnaround_time;
  } out_t;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
  } entry_t;

endpackage

[hw/rtl/round_robin_cpu_scheduler.sv]
//------------------------------------------------------------------------------
// Round-robin CPU scheduler
// Time-quantum scheduler over a process table held in synchronous memory.
//------------------------------------------------------------------------------
// A load beat inserts one process into the arrival-ordered table, moving
// later entries up one slot at a time through a read state and a compare
// state. A step beat runs one slice and gives one result beat; it scans the
// whole table once for admissions through the table memory's single read
// port, and the first step or an idle gap adds one more scan before the
// slice. A step with nothing left to run gives a status-only result beat
// without a scan. Clear, ignored loads and unused commands complete in the
// idle state. A new beat is taken while a result waits, and a step stalls at
// its result until the previous one is taken.
//------------------------------------------------------------------------------
module round_robin_cpu_scheduler #(
  parameter int MAX_PROCS = rrs_pkg::MAX_PROCS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rrs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rrs_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int TW = rrs_pkg::TIME_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_RD, S_LD_CMP, S_ST_RD, S_ST_T, S_GAP_RD, S_GAP_T,
    S_ADMIT, S_POP, S_POP_W, S_EXEC, S_RESULT
  } state_t;

  state_t          state;
  logic [15:0]     quantum;
  logic [CW-1:0]   process_count;
  logic [CW-1:0]   queue_count;
  logic [IW-1:0]   queue_head;
  logic [TW-1:0]   current_time;
  logic            started;
  logic [MAX_PROCS-1:0] done_flags;
  logic [MAX_PROCS-1:0] queued_flags;
  logic [CW-1:0]   pos;
  logic [15:0]     ld_arr;
  logic [15:0]     ld_burst;
  logic [CW-1:0]   scan_j;
  logic            scan_v;
  logic [IW-1:0]   scan_idx;
  logic            post;
  logic            skip_v;
  logic [IW-1:0]   slot;
  rrs_pkg::out_t   res;
  rrs_pkg::out_t   res_init;

  logic            t_we;
  logic [IW-1:0]   t_waddr;
  rrs_pkg::entry_t t_wentry;
  logic [IW-1:0]   t_widx;
  logic [IW-1:0]   t_raddr;
  rrs_pkg::entry_t t_rentry;
  logic [IW-1:0]   t_ridx;
  logic            q_we;
  logic [IW-1:0]   q_waddr;
  logic [IW-1:0]   q_wdata;
  logic [IW-1:0]   q_rdata;

  logic [MAX_PROCS-1:0] live;
  logic [MAX_PROCS-1:0] pending;
  logic [IW-1:0]   first_idx;
  logic [CW-1:0]   pos_m1;
  logic [CW:0]     tail_sum;
  logic [IW-1:0]   tail;
  logic [IW-1:0]   head_next;
  logic [15:0]     eff_q;
  logic [15:0]     slice;
  logic [15:0]     rem_next;
  logic [TW-1:0]   time_next;
  logic [TW-1:0]   turn;
  logic            admit_ok;
  logic            ld_shift;
  rrs_pkg::entry_t new_entry;

  rrs_table_mem #(.DEPTH(MAX_PROCS), .IW(IW)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wentry(t_wentry), .widx(t_widx),
    .raddr(t_raddr), .rentry(t_rentry), .ridx(t_ridx)
  );

  rrs_queue_mem #(.DEPTH(MAX_PROCS), .IW(IW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(queue_head), .rdata(q_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    first_idx = '0;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      live[i] = (CW'(i) < process_count);
      pending[i] = live[i] & ~done_flags[i];
      if (pending[i]) begin
        first_idx = IW'(i);
      end
    end
  end

  always_comb begin
    res_init = '0;
    res_init.status = (pending == '0);
  end

  assign pos_m1 = pos - 1'b1;
  assign tail_sum = (CW + 1)'(queue_head) + (CW + 1)'(queue_count);
  assign tail = (tail_sum >= (CW + 1)'(MAX_PROCS)) ?
                IW'(tail_sum - (CW + 1)'(MAX_PROCS)) : IW'(tail_sum);
  assign head_next = (queue_head == IW'(MAX_PROCS - 1)) ? '0 : queue_head + 1'b1;

  assign eff_q = (quantum == 16'd0) ? 16'd1 : quantum;
  assign slice = (t_rentry.remaining <= eff_q) ? t_rentry.remaining : eff_q;
  assign rem_next = t_rentry.remaining - slice;
  assign time_next = current_time + TW'(slice);
  assign turn = time_next - TW'(t_rentry.arrival);

  assign admit_ok = scan_v && !done_flags[scan_idx] && !queued_flags[scan_idx] &&
                    (TW'(t_rentry.arrival) <= current_time) &&
                    !(skip_v && scan_idx == slot);
  assign ld_shift = (t_rentry.arrival > ld_arr);
  assign new_entry = '{arrival: ld_arr, burst: ld_burst, remaining: ld_burst};

  always_comb begin
    t_we = 1'b0;
    t_waddr = pos[IW-1:0];
    t_wentry = new_entry;
    t_widx = process_count[IW-1:0];
    t_raddr = '0;
    q_we = 1'b0;
    q_waddr = tail;
    q_wdata = scan_idx;
    unique case (state)
      S_LD_RD: begin
        t_raddr = pos_m1[IW-1:0];
        t_we = (pos == '0);
      end
      S_LD_CMP: begin
        t_we = 1'b1;
        if (ld_shift) begin
          t_wentry = t_rentry;
          t_widx = t_ridx;
        end
      end
      S_GAP_RD: t_raddr = first_idx;
      S_POP_W: t_raddr = q_rdata;
      S_ADMIT: begin
        t_raddr = scan_j[IW-1:0];
        if (admit_ok) begin
          q_we = 1'b1;
        end else if (!scan_v && scan_j >= process_count && post && skip_v) begin
          q_we = 1'b1;
          q_wdata = slot;
        end
      end
      S_EXEC: begin
        t_we = 1'b1;
        t_waddr = slot;
        t_wentry = '{arrival: t_rentry.arrival, burst: t_rentry.burst,
                     remaining: rem_next};
        t_widx = t_ridx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      quantum <= rrs_pkg::QUANTUM_RESET;
      process_count <= '0;
      queue_count <= '0;
      queue_head <= '0;
      current_time <= '0;
      started <= 1'b0;
      done_flags <= '0;
      queued_flags <= '0;
      scan_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        quantum <= cfg_data;
      end
      if (out_valid && out_ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      if (q_we) begin
        queue_count <= queue_count + 1'b1;
        queued_flags[q_wdata] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (in_data.command)
              rrs_pkg::CMD_LOAD: begin
                if (!started && process_count < CW'(MAX_PROCS)) begin
                  pos <= process_count;
                  ld_arr <= in_data.arrival_tick;
                  ld_burst <= in_data.burst_ticks;
                  state <= S_LD_RD;
                end
              end
              rrs_pkg::CMD_STEP: begin
                res <= res_init;
                post <= 1'b0;
                skip_v <= 1'b0;
                if (pending == '0) begin
                  state <= S_RESULT;
                end else if (!started) begin
                  state <= S_ST_RD;
                end else if (queue_count == '0) begin
                  state <= S_GAP_RD;
                end else begin
                  state <= S_POP;
                end
              end
              rrs_pkg::CMD_CLEAR: begin
                process_count <= '0;
                queue_count <= '0;
                queue_head <= '0;
                current_time <= '0;
                started <= 1'b0;
                done_flags <= '0;
                queued_flags <= '0;
              end
              default: ;
            endcase
          end
        end
        S_LD_RD: begin
          if (pos == '0) begin
            process_count <= process_count + 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_LD_CMP;
          end
        end
        S_LD_CMP: begin
          if (ld_shift) begin
            pos <= pos_m1;
            state <= S_LD_RD;
          end else begin
            process_count <= process_count + 1'b1;
            state <= S_IDLE;
          end
        end
        S_ST_RD: state <= S_ST_T;
        S_ST_T: begin
          started <= 1'b1;
          current_time <= TW'(t_rentry.arrival);
          scan_j <= '0;
          state <= S_ADMIT;
        end
        S_GAP_RD: state <= S_GAP_T;
        S_GAP_T: begin
          if (TW'(t_rentry.arrival) > current_time) begin
            current_time <= TW'(t_rentry.arrival);
          end
          scan_j <= '0;
          state <= S_ADMIT;
        end
        S_ADMIT: begin
          if (scan_j < process_count) begin
            scan_j <= scan_j + 1'b1;
            scan_v <= 1'b1;
            scan_idx <= scan_j[IW-1:0];
          end else begin
            scan_v <= 1'b0;
            if (!scan_v) begin
              if (post) begin
                state <= S_RESULT;
              end else if (queue_count == '0) begin
                state <= S_GAP_RD;
              end else begin
                state <= S_POP;
              end
            end
          end
        end
        S_POP: begin
          queue_head <= head_next;
          queue_count <= queue_count - 1'b1;
          state <= S_POP_W;
        end
        S_POP_W: begin
          slot <= q_rdata;
          queued_flags[q_rdata] <= 1'b0;
          state <= S_EXEC;
        end
        S_EXEC: begin
          current_time <= time_next;
          res.process_id <= rrs_pkg::PID_W'(t_ridx);
          res.slice_length <= slice;
          res.slice_end_time <= time_next;
          if (rem_next == 16'd0) begin
            done_flags[slot] <= 1'b1;
            res.finished <= 1'b1;
            res.turnaround_time <= turn;
            res.wait_ticks <= turn - TW'(t_rentry.burst);
            skip_v <= 1'b0;
          end else begin
            skip_v <= 1'b1;
          end
          post <= 1'b1;
          scan_j <= '0;
          state <= S_ADMIT;
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "round_robin_cpu_scheduler_macros.svh"

  `RRS_ASSERT_ALWAYS(a_queue_bound, queue_count <= process_count, "queue exceeds table")
  `RRS_ASSERT_IMPLY(a_queue_flags, in_ready, $countones(queued_flags) == queue_count, "bad flags")
  `RRS_ASSERT_IMPLY(a_done_live, in_ready, (done_flags & ~live) == '0, "done flag beyond table")

endmodule

[hw/rtl/rrs_table_mem.sv]
//------------------------------------------------------------------------------
// Round-robin scheduler process table
// Synchronous memory of process entries with their load indexes.
//------------------------------------------------------------------------------
module rrs_table_mem #(
  parameter int DEPTH = rrs_pkg::MAX_PROCS_DEF,
  parameter int IW = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [IW-1:0]  waddr,
  input  rrs_pkg::entry_t wentry,
  input  logic [IW-1:0]  widx,
  input  logic [IW-1:0]  raddr,
  output rrs_pkg::entry_t rentry,
  output logic [IW-1:0]  ridx
);

  rrs_pkg::entry_t entries [DEPTH];
  logic [IW-1:0]   indexes [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      entries[waddr] <= wentry;
      indexes[waddr] <= widx;
    end
    rentry <= entries[raddr];
    ridx <= indexes[raddr];
  end

endmodule

[hw/rtl/rrs_queue_mem.sv]
//------------------------------------------------------------------------------
// Round-robin scheduler ready queue
// Synchronous memory holding the circular queue of table slots.
//------------------------------------------------------------------------------
module rrs_queue_mem #(
  parameter int DEPTH = rrs_pkg::MAX_PROCS_DEF,
  parameter int IW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [IW-1:0] wdata,
  input  logic [IW-1:0] raddr,
  output logic [IW-1:0] rdata
);

  logic [IW-1:0] slots [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      slots[waddr] <= wdata;
    end
    rdata <= slots[raddr];
  end

endmodule

[test/tb_round_robin_cpu_scheduler.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Round-robin CPU scheduler testbench
// Drives load, step and clear beats with random idling on both channels and
// checks every slice report against a cycle-free scheduler written in place.
//------------------------------------------------------------------------------
module tb_round_robin_cpu_scheduler;

  localparam int NPROC = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 80;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  rrs_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  rrs_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [15:0]   cfg_data;

  round_robin_cpu_scheduler u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Scheduler state mirrored for prediction.
  logic [15:0]       arr_tab [NPROC];
  logic [15:0]       burst_tab [NPROC];
  logic [15:0]       rem_tab [NPROC];
  logic [3:0]        lidx_tab [NPROC];
  logic              done_tab [NPROC];
  logic              queued_tab [NPROC];
  logic [3:0]        ready_fifo [NPROC];
  int                fifo_head;
  int                fifo_count;
  int                proc_count;
  logic [rrs_pkg::TIME_W-1:0] now_tick;
  logic              running;
  logic [15:0]       quantum;

  rrs_pkg::out_t expected_slices[$];
  int   errors;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   hold_reqs;
  int   hold_seen;
  int   hold_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void sched_clear();
    for (int j = 0; j < NPROC; j++) begin
      arr_tab[j] = '0;
      burst_tab[j] = '0;
      rem_tab[j] = '0;
      lidx_tab[j] = '0;
      done_tab[j] = 1'b0;
      queued_tab[j] = 1'b0;
      ready_fifo[j] = '0;
    end
    fifo_head = 0;
    fifo_count = 0;
    proc_count = 0;
    now_tick = '0;
    running = 1'b0;
  endfunction

  function automatic void fifo_push(int slot);
    if (fifo_count >= NPROC) return;
    ready_fifo[(fifo_head + fifo_count) % NPROC] = slot[3:0];
    fifo_count++;
    queued_tab[slot] = 1'b1;
  endfunction

  function automatic void admit_arrived(int skip);
    for (int j = 0; j < proc_count; j++)
      if (j != skip && !done_tab[j] && !queued_tab[j] && arr_tab[j] <= now_tick)
        fifo_push(j);
  endfunction

  function automatic void sched_load(logic [15:0] a, logic [15:0] b);
    int pos;
    if (running || proc_count >= NPROC) return;
    pos = proc_count;
    while (pos > 0 && arr_tab[pos-1] > a) begin
      arr_tab[pos] = arr_tab[pos-1];
      burst_tab[pos] = burst_tab[pos-1];
      rem_tab[pos] = rem_tab[pos-1];
      lidx_tab[pos] = lidx_tab[pos-1];
      done_tab[pos] = done_tab[pos-1];
      queued_tab[pos] = queued_tab[pos-1];
      pos--;
    end
    arr_tab[pos] = a;
    burst_tab[pos] = b;
    rem_tab[pos] = b;
    lidx_tab[pos] = proc_count[3:0];
    done_tab[pos] = 1'b0;
    queued_tab[pos] = 1'b0;
    proc_count++;
  endfunction

  function automatic int pending_procs();
    int n;
    n = 0;
    for (int j = 0; j < proc_count; j++)
      if (!done_tab[j]) n++;
    return n;
  endfunction

  function automatic rrs_pkg::out_t sched_step();
    rrs_pkg::out_t     r;
    int                slot;
    logic [15:0]       qe;
    logic [15:0]       slice;
    logic [rrs_pkg::TIME_W-1:0] turn;
    r = '0;
    if (pending_procs() == 0) begin
      r.status = 1'b1;
      return r;
    end
    if (!running) begin
      running = 1'b1;
      now_tick = arr_tab[0];
      admit_arrived(NPROC);
    end
    if (fifo_count == 0) begin
      for (int j = 0; j < proc_count; j++) begin
        if (!done_tab[j]) begin
          if (arr_tab[j] > now_tick) now_tick = arr_tab[j];
          break;
        end
      end
      admit_arrived(NPROC);
    end
    slot = ready_fifo[fifo_head];
    fifo_head = (fifo_head + 1) % NPROC;
    fifo_count--;
    queued_tab[slot] = 1'b0;
    qe = (quantum == 0) ? 16'd1 : quantum;
    slice = (rem_tab[slot] <= qe) ? rem_tab[slot] : qe;
    now_tick = now_tick + slice;
    rem_tab[slot] = rem_tab[slot] - slice;
    r.process_id = lidx_tab[slot];
    r.slice_length = slice;
    r.slice_end_time = now_tick;
    if (rem_tab[slot] == 0) begin
      turn = now_tick - arr_tab[slot];
      done_tab[slot] = 1'b1;
      r.finished = 1'b1;
      r.wait_ticks = turn - burst_tab[slot];
      r.turnaround_time = turn;
      admit_arrived(NPROC);
    end else begin
      admit_arrived(slot);
      fifo_push(slot);
    end
    return r;
  endfunction

  // Receiver: random back-pressure plus requested long holds.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result beats are checked on the falling edge ahead of the edge that takes them.
  always @(negedge clk) begin
    rrs_pkg::out_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_slices.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_data);
        errors++;
      end else begin
        e = expected_slices.pop_front();
        if (out_data.status !== e.status || out_data.process_id !== e.process_id ||
            out_data.slice_length !== e.slice_length ||
            out_data.slice_end_time !== e.slice_end_time ||
            out_data.finished !== e.finished ||
            out_data.wait_ticks !== e.wait_ticks ||
            out_data.turnaround_time !== e.turnaround_time) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [15:0] a, logic [15:0] b);
    logic         taken;
    rrs_pkg::in_t item;
    item.command = cmd;
    item.arrival_tick = a;
    item.burst_ticks = b;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    case (cmd)
      rrs_pkg::CMD_LOAD: sched_load(a, b);
      rrs_pkg::CMD_STEP: expected_slices.push_back(sched_step());
      rrs_pkg::CMD_CLEAR: sched_clear();
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_slices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_quantum(logic [15:0] v);
    logic taken;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    quantum = v;
  endtask

  task automatic run_to_completion();
    while (pending_procs() > 0)
      send_item(rrs_pkg::CMD_STEP, 16'($urandom), 16'($urandom));
    send_item(rrs_pkg::CMD_STEP, '0, '0);
  endtask

  task automatic test_directed();
    send_item(rrs_pkg::CMD_STEP, '0, '0);
    send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
    send_item(rrs_pkg::CMD_CLEAR, '0, '0);
    send_item(rrs_pkg::CMD_LOAD, 16'd10, 16'd5);
    send_item(rrs_pkg::CMD_LOAD, 16'd3, 16'd0);
    send_item(rrs_pkg::CMD_LOAD, 16'd10, 16'd2);
    send_item(rrs_pkg::CMD_LOAD, 16'd40, 16'd3);
    send_item(rrs_pkg::CMD_STEP, '0, '0);
    send_item(rrs_pkg::CMD_LOAD, 16'd0, 16'd1);
    run_to_completion();
    send_item(rrs_pkg::CMD_CLEAR, '0, '0);
  endtask

  task automatic test_quantum_extremes();
    write_quantum(16'hFFFF);
    send_item(rrs_pkg::CMD_LOAD, 16'hFFFF, 16'hFFFF);
    send_item(rrs_pkg::CMD_LOAD, 16'h0000, 16'h0001);
    send_item(rrs_pkg::CMD_LOAD, 16'h8000, 16'hFFFF);
    run_to_completion();
    write_quantum(16'h0000);
    send_item(rrs_pkg::CMD_CLEAR, '0, '0);
    send_item(rrs_pkg::CMD_LOAD, 16'd5, 16'd3);
    send_item(rrs_pkg::CMD_LOAD, 16'd5, 16'd2);
    run_to_completion();
    send_item(rrs_pkg::CMD_CLEAR, '0, '0);
  endtask

  task automatic random_set(int limit);
    int          n;
    int          qe;
    logic [15:0] a;
    logic [15:0] b;
    n = $urandom_range(1, NPROC);
    if ($urandom_range(7) == 0) n = $urandom_range(NPROC, NPROC + 2);
    qe = (quantum == 0) ? 1 : quantum;
    send_item(rrs_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom));
    for (int k = 0; k < n; k++) begin
      a = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
      b = 16'($urandom_range(1, (3 * qe > 65535) ? 65535 : 3 * qe));
      if (qe > 4000 && $urandom_range(3) == 0) b = 16'($urandom);
      send_item(rrs_pkg::CMD_LOAD, a, b);
      if ($urandom_range(19) == 0) send_item(CMD_UNUSED, 16'($urandom), 16'($urandom));
    end
    while (pending_procs() > 0 && limit > 0) begin
      send_item(rrs_pkg::CMD_STEP, 16'($urandom), 16'($urandom));
      limit--;
      if ($urandom_range(24) == 0)
        send_item(rrs_pkg::CMD_LOAD, 16'($urandom), 16'($urandom));
      if ($urandom_range(59) == 0) begin
        send_item(rrs_pkg::CMD_CLEAR, '0, '0);
        return;
      end
    end
    if ($urandom_range(1) == 0) send_item(rrs_pkg::CMD_STEP, '0, '0);
  endtask

  task automatic test_random_phase(int target);
    logic [15:0] qs [6];
    qs = '{16'd1, 16'd3, 16'd4, 16'd7, 16'd0, 16'hFFFF};
    for (int sets = 0; sets < target / 28; sets++) begin
      if ($urandom_range(2) == 0) begin
        if ($urandom_range(3) == 0) write_quantum(16'($urandom_range(1, 12)));
        else write_quantum(qs[$urandom_range(0, 5)]);
      end
      random_set(60);
    end
  endtask

  task automatic test_backpressure();
    write_quantum(16'd2);
    send_item(rrs_pkg::CMD_CLEAR, '0, '0);
    for (int k = 0; k < NPROC; k++)
      send_item(rrs_pkg::CMD_LOAD, 16'($urandom_range(0, 20)), 16'($urandom_range(1, 6)));
    hold_reqs++;
    for (int k = 0; k < 20; k++)
      send_item(rrs_pkg::CMD_STEP, '0, '0);
    wait_drained();
    run_to_completion();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    hold_reqs = 0;
    tx_idle_pct = 37;
    rx_idle_pct = 63;
    quantum = rrs_pkg::QUANTUM_RESET;
    sched_clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_quantum_extremes();
    test_random_phase(230);
    tx_idle_pct = 63;
    rx_idle_pct = 37;
    test_backpressure();
    test_random_phase(230);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_phase(230);
    wait_drained();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
